// ===== src/tccw_pkg.sv =====
// Shared types and constants of the text console cell writer.
// Used by tccw_ctrl, tccw_datapath and text_console_cell_writer; depends on nothing.
package tccw_pkg;

  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  // Field widths of one input item and one result item.
  localparam int ACTION_W = 2;
  localparam int CHAR_W   = 8;
  localparam int TARGET_W = 12;
  localparam int CURX_W   = 7;
  localparam int CURY_W   = 5;
  localparam int CELL_W   = 16;
  localparam int FG_W     = 4;
  localparam int BG_W     = 3;

  localparam int S_TDATA_W = 40;  // 34 bits of fields padded to whole bytes
  localparam int M_TDATA_W = 32;  // 29 bits of fields padded to whole bytes

  // Configuration register indexes.
  localparam logic [0:0] REG_FG = 1'b0;
  localparam logic [0:0] REG_BG = 1'b1;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  localparam logic [FG_W-1:0]   RESET_FG   = 4'd7;
  localparam logic [BG_W-1:0]   RESET_BG   = 3'd1;
  localparam logic [CELL_W-1:0] RESET_CELL = 16'h1720;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUT   = 2'd0,
    ACT_GOTO  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_READ  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    SW_INIT   = 2'd0,
    SW_CLEAR  = 2'd1,
    SW_SCROLL = 2'd2
  } sweep_kind_e;

  typedef struct packed {
    logic load_item;    // capture the accepted item
    logic calc_addr;    // form the cell address
    logic exec;         // apply put, goto or clear to cursor and store
    logic rd_en;        // read the addressed cell
    logic sweep_start;  // start a clear or scroll sweep
    logic out_load;     // load the result register
  } cmd_t;

  typedef struct packed {
    action_e action;      // action of the held item
    logic    put_scroll;  // the held put moves the cursor past the bottom row
    logic    sweep_busy;  // a sweep is still reading or writing
    logic    sweep_done;  // last write of the sweep happens this cycle
    logic    out_free;    // the result register can take a new result
  } sts_t;

endpackage

// ===== src/tccw_ctrl.sv =====
// Controller state machine of the text console cell writer.
// Depends on tccw_pkg for the command and status structs.
module tccw_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_valid_i,
  output logic           s_ready_o,
  input  tccw_pkg::sts_t sts_i,
  output tccw_pkg::cmd_t cmd_o
);
  import tccw_pkg::*;

  localparam logic [2:0] ST_INIT  = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_ADDR  = 3'd2;
  localparam logic [2:0] ST_EXEC  = 3'd3;
  localparam logic [2:0] ST_SWEEP = 3'd4;
  localparam logic [2:0] ST_RESP  = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_INIT: begin
        if (sts_i.sweep_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = ST_ADDR;
        end
      end
      ST_ADDR: begin
        cmd_o.calc_addr = 1'b1;
        state_d         = ST_EXEC;
      end
      ST_EXEC: begin
        unique case (sts_i.action)
          ACT_PUT: begin
            cmd_o.exec = 1'b1;
            if (sts_i.put_scroll) begin
              cmd_o.sweep_start = 1'b1;
              state_d           = ST_SWEEP;
            end else begin
              state_d = ST_RESP;
            end
          end
          ACT_GOTO: begin
            cmd_o.exec = 1'b1;
            state_d    = ST_RESP;
          end
          ACT_CLEAR: begin
            cmd_o.exec        = 1'b1;
            cmd_o.sweep_start = 1'b1;
            state_d           = ST_SWEEP;
          end
          ACT_READ: begin
            cmd_o.rd_en = 1'b1;
            state_d     = ST_RESP;
          end
          default: state_d = ST_RESP;
        endcase
      end
      ST_SWEEP: begin
        if (sts_i.sweep_done) begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  assign s_ready_o = (state_q == ST_IDLE);

endmodule

// ===== src/tccw_datapath.sv =====
// Datapath of the text console cell writer: item registers, cursor, colour
// registers, the cell store with its sweep engine, and the result register.
// Depends on tccw_pkg.
module tccw_datapath #(
  parameter int COLUMNS = tccw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tccw_pkg::DEF_ROWS
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  tccw_pkg::cmd_t                        cmd_i,
  output tccw_pkg::sts_t                        sts_o,
  input  logic                                  cfg_we_i,
  input  logic [0:0]                            cfg_index_i,
  input  logic [tccw_pkg::FG_W-1:0]             cfg_data_i,
  input  logic [tccw_pkg::ACTION_W-1:0]         action_i,
  input  logic [tccw_pkg::CHAR_W-1:0]           char_code_i,
  input  logic signed [tccw_pkg::TARGET_W-1:0]  target_x_i,
  input  logic signed [tccw_pkg::TARGET_W-1:0]  target_y_i,
  input  logic                                  m_ready_i,
  output logic                                  m_valid_o,
  output logic [tccw_pkg::CURX_W-1:0]           cursor_x_o,
  output logic [tccw_pkg::CURY_W-1:0]           cursor_y_o,
  output logic [tccw_pkg::CELL_W-1:0]           cell_word_o,
  output logic                                  scrolled_o
);
  import tccw_pkg::*;

  localparam int CELLS     = ROWS * COLUMNS;
  localparam int AW        = $clog2(CELLS);
  localparam int CW        = $clog2(COLUMNS);
  localparam int RW        = $clog2(ROWS);
  localparam int LAST_BASE = (ROWS - 1) * COLUMNS;

  // Item and cursor registers.
  action_e           action_q;
  logic [CHAR_W-1:0] char_q;
  logic [CW-1:0]     tx_q, tx_d;
  logic [RW-1:0]     ty_q, ty_d;
  logic [CW-1:0]     col_q, col_d;
  logic [RW-1:0]     row_q, row_d;
  logic [AW-1:0]     addr_q;
  logic [FG_W-1:0]   fg_q;
  logic [BG_W-1:0]   bg_q;
  logic              scroll_flag_q;

  // Sweep engine.
  sweep_kind_e       kind_q;
  logic              rd_busy_q;
  logic [AW-1:0]     idx_q;
  logic              wb_valid_q;
  logic              wb_last_q;
  logic              wb_tail_q;
  logic [AW-1:0]     wb_addr_q;
  logic [AW-1:0]     sweep_raddr;

  // Cell store.
  logic [CELL_W-1:0] mem [CELLS];
  logic [CELL_W-1:0] rdata_q;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [CELL_W-1:0] mem_wdata;
  logic [CELL_W-1:0] blank_cell;

  // Result register.
  logic              out_valid_q;
  logic [CURX_W-1:0] out_x_q;
  logic [CURY_W-1:0] out_y_q;
  logic [CELL_W-1:0] out_word_q;
  logic              out_scroll_q;

  logic printable, col_last, row_last, advance_row;
  logic [RW-1:0] row_sel;
  logic [CW-1:0] col_sel;

  // Saturate the signed targets into the screen.
  always_comb begin
    if (target_x_i[TARGET_W-1]) begin
      tx_d = '0;
    end else if (target_x_i >= TARGET_W'(COLUMNS)) begin
      tx_d = CW'(COLUMNS - 1);
    end else begin
      tx_d = CW'(target_x_i);
    end
    if (target_y_i[TARGET_W-1]) begin
      ty_d = '0;
    end else if (target_y_i >= TARGET_W'(ROWS)) begin
      ty_d = RW'(ROWS - 1);
    end else begin
      ty_d = RW'(target_y_i);
    end
  end

  assign printable   = (char_q != CH_NUL) && (char_q != CH_TAB) &&
                       (char_q != CH_LF) && (char_q != CH_CR);
  assign col_last    = (col_q == CW'(COLUMNS - 1));
  assign row_last    = (row_q == RW'(ROWS - 1));
  assign advance_row = (char_q == CH_LF) || (printable && col_last);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cmd_i.exec) begin
      unique case (action_q)
        ACT_PUT: begin
          if ((char_q == CH_LF) || (char_q == CH_CR) || (printable && col_last)) begin
            col_d = '0;
          end else if (printable) begin
            col_d = col_q + CW'(1);
          end
          // Past the bottom row the scroll keeps the cursor on the last row.
          if (advance_row && !row_last) begin
            row_d = row_q + RW'(1);
          end
        end
        ACT_GOTO: begin
          col_d = tx_q;
          row_d = ty_q;
        end
        ACT_CLEAR: begin
          col_d = '0;
          row_d = '0;
        end
        ACT_READ: ;
        default: ;
      endcase
    end
  end

  assign row_sel = (action_q == ACT_READ) ? ty_q : row_q;
  assign col_sel = (action_q == ACT_READ) ? tx_q : col_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      action_q <= action_e'(action_i);
      char_q   <= char_code_i;
      tx_q     <= tx_d;
      ty_q     <= ty_d;
    end
    if (cmd_i.calc_addr) begin
      addr_q <= AW'(AW'(row_sel) * AW'(COLUMNS) + AW'(col_sel));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q         <= '0;
      row_q         <= '0;
      fg_q          <= RESET_FG;
      bg_q          <= RESET_BG;
      scroll_flag_q <= 1'b0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (cfg_we_i && (cfg_index_i == REG_FG)) begin
        fg_q <= cfg_data_i;
      end
      if (cfg_we_i && (cfg_index_i == REG_BG)) begin
        bg_q <= BG_W'(cfg_data_i);
      end
      if (cmd_i.load_item) begin
        scroll_flag_q <= 1'b0;
      end else if (cmd_i.sweep_start && (action_q == ACT_PUT)) begin
        scroll_flag_q <= 1'b1;
      end
    end
  end

  // The sweep reads one cell per cycle and writes it back in the next cycle.
  // A scroll reads one row below for all but the last row, which it reads in
  // place to blank the character bytes.
  assign sweep_raddr = (idx_q < AW'(LAST_BASE)) ? AW'(idx_q + AW'(COLUMNS)) : idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q     <= SW_INIT;
      rd_busy_q  <= 1'b1;
      idx_q      <= '0;
      wb_valid_q <= 1'b0;
      wb_last_q  <= 1'b0;
      wb_tail_q  <= 1'b0;
      wb_addr_q  <= '0;
    end else begin
      if (cmd_i.sweep_start) begin
        kind_q    <= (action_q == ACT_CLEAR) ? SW_CLEAR : SW_SCROLL;
        rd_busy_q <= 1'b1;
        idx_q     <= '0;
      end else if (rd_busy_q) begin
        if (idx_q == AW'(CELLS - 1)) begin
          rd_busy_q <= 1'b0;
          idx_q     <= '0;
        end else begin
          idx_q <= idx_q + AW'(1);
        end
      end
      wb_valid_q <= rd_busy_q;
      wb_last_q  <= rd_busy_q && (idx_q == AW'(CELLS - 1));
      wb_tail_q  <= (idx_q >= AW'(LAST_BASE));
      wb_addr_q  <= idx_q;
    end
  end

  assign blank_cell = {1'b0, bg_q, fg_q, CH_SPACE};

  always_comb begin
    mem_we    = wb_valid_q || (cmd_i.exec && (action_q == ACT_PUT) && printable);
    mem_waddr = wb_valid_q ? wb_addr_q : addr_q;
    mem_wdata = {1'b0, bg_q, fg_q, char_q};
    if (wb_valid_q) begin
      unique case (kind_q)
        SW_INIT:   mem_wdata = RESET_CELL;
        SW_CLEAR:  mem_wdata = blank_cell;
        SW_SCROLL: mem_wdata = wb_tail_q ? {rdata_q[CELL_W-1:CHAR_W], CH_SPACE} : rdata_q;
        default:   mem_wdata = RESET_CELL;
      endcase
    end
    mem_re    = rd_busy_q || cmd_i.rd_en;
    mem_raddr = rd_busy_q ? sweep_raddr : addr_q;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  // Result register: a finished result waits here while the next item enters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_x_q      <= CURX_W'(col_q);
      out_y_q      <= CURY_W'(row_q);
      out_word_q   <= (action_q == ACT_READ) ? rdata_q : '0;
      out_scroll_q <= scroll_flag_q;
    end
  end

  assign m_valid_o   = out_valid_q;
  assign cursor_x_o  = out_x_q;
  assign cursor_y_o  = out_y_q;
  assign cell_word_o = out_word_q;
  assign scrolled_o  = out_scroll_q;

  assign sts_o.action     = action_q;
  assign sts_o.put_scroll = advance_row && row_last;
  assign sts_o.sweep_busy = rd_busy_q || wb_valid_q;
  assign sts_o.sweep_done = wb_valid_q && wb_last_q;
  assign sts_o.out_free   = !out_valid_q || m_ready_i;

endmodule

// ===== src/text_console_cell_writer.sv =====
// Top level of the text console cell writer: stream ports, field packing,
// controller and datapath. Depends on tccw_pkg, tccw_ctrl and tccw_datapath.
//
// The block keeps a ROWS x COLUMNS store of 16-bit character cells (bits 7:0
// character, 11:8 foreground, 14:12 background, 15 blink) and a cursor. Each
// input item carries one action: put a character at the cursor, go to a
// clamped position, clear the screen, or read one cell. Every item yields
// exactly one result with the cursor after the action, the cell word for a
// read (zero otherwise) and a flag that tells whether the screen scrolled.
// Items are handled one at a time: each accepted item passes through an
// address step, an execute step and a response step before the next item is
// accepted, and the response step waits while a result is still untaken.
// Clear, and a put that scrolls, also sweep the whole cell store one cell per
// cycle. After reset the store is filled with blank cells by the same sweep,
// during which no item is accepted; configuration writes are taken at any
// time. A finished result waits in an output register, so the next item is
// accepted while the previous result is still waiting to be taken.
module text_console_cell_writer #(
  parameter int COLUMNS = tccw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tccw_pkg::DEF_ROWS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration: index 0 foreground colour, index 1 background colour.
  input  logic                             cfg_we_i,
  input  logic [0:0]                       cfg_index_i,
  input  logic [tccw_pkg::FG_W-1:0]        cfg_data_i,
  // Input items.
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // tdata, from bit 0: action[1:0], char_code[9:2], target_x[21:10],
  // target_y[33:22], zero padding[39:34].
  input  logic [tccw_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // Result items.
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // tdata, from bit 0: cursor_x[6:0], cursor_y[11:7], cell_word[27:12],
  // scrolled[28], zero padding[31:29].
  output logic [tccw_pkg::M_TDATA_W-1:0]   m_axis_tdata
);
  import tccw_pkg::*;

  cmd_t cmd;
  sts_t sts;

  logic [CURX_W-1:0] cursor_x;
  logic [CURY_W-1:0] cursor_y;
  logic [CELL_W-1:0] cell_word;
  logic              scrolled;

  tccw_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  tccw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .action_i    (s_axis_tdata[1:0]),
    .char_code_i (s_axis_tdata[9:2]),
    .target_x_i  (s_axis_tdata[21:10]),
    .target_y_i  (s_axis_tdata[33:22]),
    .m_ready_i   (m_axis_tready),
    .m_valid_o   (m_axis_tvalid),
    .cursor_x_o  (cursor_x),
    .cursor_y_o  (cursor_y),
    .cell_word_o (cell_word),
    .scrolled_o  (scrolled)
  );

  assign m_axis_tdata = {3'b000, scrolled, cell_word, cursor_y, cursor_x};

`ifndef NO_ASSERTIONS
  // A new result never overwrites one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> sts.out_free)
    else $error("result register overwritten");

  // No item is taken while the store is being swept.
  a_idle_no_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !sts.sweep_busy)
    else $error("item accepted during a sweep");

  // A scroll leaves the cursor on the bottom row.
  a_scroll_bottom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[28]) |-> (m_axis_tdata[11:7] == CURY_W'(ROWS - 1)))
    else $error("scroll result not on the bottom row");

  // A sweep starts only for a clear or for a put that scrolls.
  a_sweep_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.sweep_start |-> ((sts.action == ACT_CLEAR) || sts.put_scroll))
    else $error("sweep started without clear or scroll");
`endif

endmodule

// ===== verif/tb_text_console_cell_writer.sv =====
// Self-checking testbench of the text console cell writer: a cell-store mirror
// class predicts every result, plain tasks drive the stream and config ports.
// Depends on tccw_pkg and text_console_cell_writer.
module tb_text_console_cell_writer;
  timeunit 1ns;
  timeprecision 1ps;

  import tccw_pkg::*;

  localparam int CELL_COUNT   = DEF_ROWS * DEF_COLUMNS;
  // The limit leaves a wide margin over the slowest correct run, even if every
  // item cleared the screen.
  localparam int CYCLE_LIMIT  = 3000000;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_ITEMS  = 75;
  localparam int SETTLE_TICKS = 40;

  // One input item, as the fields of s_axis_tdata.
  typedef struct {
    action_e             act;
    logic [CHAR_W-1:0]   code;
    logic [TARGET_W-1:0] tx;
    logic [TARGET_W-1:0] ty;
  } console_item_t;

  // One result item, as the fields of m_axis_tdata.
  typedef struct {
    logic [CURX_W-1:0] cur_x;
    logic [CURY_W-1:0] cur_y;
    logic [CELL_W-1:0] cell_word;
    logic              scrolled;
  } console_result_t;

  // Mirror of the console: its own copy of the cell store, the cursor and the
  // two color registers. Every accepted item is applied here at once and the
  // result it must produce is queued until the block delivers it.
  class console_mirror;
    logic [CELL_W-1:0] cells [CELL_COUNT];
    int                col;
    int                row;
    logic [FG_W-1:0]   fg;
    logic [BG_W-1:0]   bg;
    console_result_t   pending_results [$];
    int                mismatches;

    function new();
      fg  = RESET_FG;
      bg  = RESET_BG;
      col = 0;
      row = 0;
      mismatches = 0;
      foreach (cells[i]) cells[i] = RESET_CELL;
    endfunction

    function void set_color(logic [0:0] idx, logic [FG_W-1:0] value);
      if (idx == REG_FG) fg = value;
      else bg = value[BG_W-1:0];
    endfunction

    function int clamp_coord(logic [TARGET_W-1:0] raw, int lim);
      int v;
      v = int'($signed(raw));
      if (v < 0) return 0;
      if (v >= lim) return lim - 1;
      return v;
    endfunction

    function void note_item(console_item_t it);
      console_result_t res;
      int              cx;
      int              cy;
      cx = clamp_coord(it.tx, DEF_COLUMNS);
      cy = clamp_coord(it.ty, DEF_ROWS);
      res.cell_word = '0;
      res.scrolled  = 1'b0;
      case (it.act)
        ACT_PUT: begin
          if (it.code == CH_NUL || it.code == CH_TAB) begin
            // Ignored codes leave everything as it is.
          end else if (it.code == CH_LF) begin
            col = 0;
            row++;
          end else if (it.code == CH_CR) begin
            col = 0;
          end else begin
            cells[row * DEF_COLUMNS + col] = {1'b0, bg, fg, it.code};
            col++;
            if (col >= DEF_COLUMNS) begin
              col = 0;
              row++;
            end
          end
          if (row >= DEF_ROWS) begin
            // Scroll: rows move up, the last row keeps its colors but its
            // characters turn into spaces.
            for (int i = 0; i < (DEF_ROWS - 1) * DEF_COLUMNS; i++)
              cells[i] = cells[i + DEF_COLUMNS];
            for (int i = (DEF_ROWS - 1) * DEF_COLUMNS; i < CELL_COUNT; i++)
              cells[i] = {cells[i][15:8], CH_SPACE};
            row = DEF_ROWS - 1;
            res.scrolled = 1'b1;
          end
        end
        ACT_GOTO: begin
          col = cx;
          row = cy;
        end
        ACT_CLEAR: begin
          foreach (cells[i]) cells[i] = {1'b0, bg, fg, CH_SPACE};
          col = 0;
          row = 0;
        end
        default: res.cell_word = cells[cy * DEF_COLUMNS + cx];
      endcase
      res.cur_x = col[CURX_W-1:0];
      res.cur_y = row[CURY_W-1:0];
      pending_results.push_back(res);
    endfunction

    task report(string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      mismatches++;
    endtask

    task check_result(logic [M_TDATA_W-1:0] word);
      console_result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("result 0x%08h arrived with nothing expected", word));
      end else begin
        want = pending_results.pop_front();
        if (word[6:0] != want.cur_x)
          report($sformatf("cursor_x %0d, expected %0d", word[6:0], want.cur_x));
        if (word[11:7] != want.cur_y)
          report($sformatf("cursor_y %0d, expected %0d", word[11:7], want.cur_y));
        if (word[27:12] != want.cell_word)
          report($sformatf("cell_word 0x%04h, expected 0x%04h", word[27:12],
                           want.cell_word));
        if (word[28] != want.scrolled)
          report($sformatf("scrolled %0b, expected %0b", word[28], want.scrolled));
      end
    endtask
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [0:0]           cfg_index_i;
  logic [FG_W-1:0]      cfg_data_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  // action[1:0], char_code[9:2], target_x[21:10], target_y[33:22], zeros[39:34]
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  // cursor_x[6:0], cursor_y[11:7], cell_word[27:12], scrolled[28], zeros[31:29]
  logic [M_TDATA_W-1:0] m_axis_tdata;

  // Idle and stall rates in percent per cycle, set by the phase in progress.
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  // The long receiver hold-off: requested by the stimulus, timed on its own.
  logic        hold_start;
  logic        hold_done;

  console_mirror mirror = new();

  text_console_cell_writer u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Timeout: a hung handshake or a lost result ends the run here.
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("text_console_cell_writer verification failed");
    $finish;
  end

  // Result side. Outputs are sampled at the rising edge, before any update of
  // that edge lands, and tready for the next cycle is drawn afterwards. While
  // the hold-off runs, tready stays low so that the block backs up.
  initial begin : result_sink
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) mirror.check_result(m_axis_tdata);
      m_axis_tready <= !(hold_start && !hold_done) &&
                       ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Counts out the long hold-off once the stimulus asks for it.
  initial begin : receiver_hold_off
    hold_done = 1'b0;
    wait (hold_start);
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_done <= 1'b1;
  end

  function automatic console_item_t item_of(action_e a, logic [CHAR_W-1:0] c,
                                            logic [TARGET_W-1:0] x,
                                            logic [TARGET_W-1:0] y);
    console_item_t it;
    it.act  = a;
    it.code = c;
    it.tx   = x;
    it.ty   = y;
    return it;
  endfunction

  // Mostly puts of printable characters, with line feeds, returns and ignored
  // codes mixed in; gotos and reads mostly land on the screen, some far off it
  // so that clamping on both edges is hit. Clears stay rare since each one
  // sweeps the whole store. Unused fields still carry random bits.
  function automatic console_item_t random_item();
    console_item_t it;
    int unsigned   pick;
    pick    = $urandom_range(99);
    it.code = CHAR_W'($urandom_range(255));
    it.tx   = TARGET_W'($urandom_range(4095));
    it.ty   = TARGET_W'($urandom_range(4095));
    if (pick < 55) begin
      it.act = ACT_PUT;
      case ($urandom_range(9))
        0: it.code = CH_LF;
        1: it.code = CH_CR;
        2: it.code = $urandom_range(1) ? CH_NUL : CH_TAB;
        default: ;
      endcase
    end else if (pick < 96) begin
      it.act = (pick < 72) ? ACT_GOTO : ACT_READ;
      if ($urandom_range(9) < 7) begin
        it.tx = TARGET_W'($urandom_range(DEF_COLUMNS - 1));
        it.ty = TARGET_W'($urandom_range(DEF_ROWS - 1));
      end
    end else begin
      it.act = ACT_CLEAR;
    end
    return it;
  endfunction

  // Offers one item, waits for the handshake, hands it to the mirror, and
  // then maybe idles for a random number of cycles.
  task automatic send_item(console_item_t it);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, it.ty, it.tx, it.code, it.act};
    do @(posedge clk_i); while (!s_axis_tready);
    mirror.note_item(it);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // Stops offering items and waits until every expected result has come.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (mirror.pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Writes the foreground color register and then the background one. Only called when
  // the block has nothing in flight.
  task automatic write_colors(logic [FG_W-1:0] fg, logic [FG_W-1:0] bg);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_FG;
    cfg_data_i  <= fg;
    @(posedge clk_i);
    mirror.set_color(REG_FG, fg);
    cfg_index_i <= REG_BG;
    cfg_data_i  <= bg;
    @(posedge clk_i);
    mirror.set_color(REG_BG, bg);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic run_random(int count, int unsigned idle_pct, int unsigned stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_item(random_item());
  endtask

  initial begin : stimulus
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_index_i    = REG_FG;
    cfg_data_i     = '0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    hold_start     = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part with the reset colors. The first item waits out the
    // clearing sweep after reset through the handshake alone.
    send_item(item_of(ACT_READ, 8'h00, 12'h800, 12'h800));   // clamps to 0,0
    send_item(item_of(ACT_READ, 8'hFF, 12'h7FF, 12'h7FF));   // clamps to 79,24
    send_item(item_of(ACT_PUT, 8'h41, 12'h000, 12'h000));
    send_item(item_of(ACT_PUT, CH_NUL, 12'hFFF, 12'hFFF));
    send_item(item_of(ACT_PUT, CH_TAB, 12'h000, 12'h000));
    send_item(item_of(ACT_PUT, 8'hFF, 12'h000, 12'h000));
    send_item(item_of(ACT_PUT, CH_CR, 12'h000, 12'h000));
    send_item(item_of(ACT_READ, 8'h00, 12'd1, 12'd0));
    send_item(item_of(ACT_PUT, CH_LF, 12'h000, 12'h000));
    send_item(item_of(ACT_GOTO, 8'h00, 12'h7FF, 12'h7FF));
    // A put in the bottom right corner wraps past the last row and scrolls.
    send_item(item_of(ACT_PUT, 8'h01, 12'h000, 12'h000));
    send_item(item_of(ACT_READ, 8'h00, 12'd79, 12'd23));
    send_item(item_of(ACT_READ, 8'h00, 12'd0, 12'd24));
    // A line feed on the bottom row scrolls as well.
    send_item(item_of(ACT_PUT, CH_LF, 12'h000, 12'h000));
    send_item(item_of(ACT_GOTO, 8'h00, 12'hFFF, 12'hFFF));  // -1,-1 clamps to 0,0
    send_item(item_of(ACT_GOTO, 8'h00, 12'd78, 12'd24));
    send_item(item_of(ACT_PUT, 8'h78, 12'h000, 12'h000));
    send_item(item_of(ACT_PUT, CH_CR, 12'h000, 12'h000));
    send_item(item_of(ACT_READ, 8'h00, 12'd78, 12'd24));
    send_item(item_of(ACT_CLEAR, 8'h00, 12'h000, 12'h000));
    send_item(item_of(ACT_READ, 8'h00, 12'd40, 12'd12));
    wait_drained();

    // Extreme colors, then the opposite extremes.
    write_colors(4'd15, 4'd0);
    send_item(item_of(ACT_PUT, 8'h5A, 12'h000, 12'h000));
    send_item(item_of(ACT_READ, 8'h00, 12'd0, 12'd0));
    send_item(item_of(ACT_CLEAR, 8'h00, 12'h000, 12'h000));
    wait_drained();
    write_colors(4'd0, 4'd7);
    send_item(item_of(ACT_PUT, 8'h80, 12'h000, 12'h000));
    send_item(item_of(ACT_READ, 8'h00, 12'd0, 12'd0));
    wait_drained();

    // Random phases. The first runs without idling and starts the long
    // receiver hold-off, so the block fills up and stops taking items.
    hold_start <= 1'b1;
    run_random(PHASE_ITEMS, 0, 0);
    wait_drained();
    write_colors(FG_W'($urandom_range(15)), FG_W'($urandom_range(15)));
    run_random(PHASE_ITEMS, 82, 0);
    wait_drained();
    write_colors(FG_W'($urandom_range(15)), FG_W'($urandom_range(15)));
    run_random(PHASE_ITEMS, 0, 82);
    wait_drained();
    write_colors(FG_W'($urandom_range(15)), FG_W'($urandom_range(15)));
    run_random(PHASE_ITEMS, 35, 35);

    wait_drained();
    // The settle wait lets a stray extra result still be caught.
    repeat (SETTLE_TICKS) @(posedge clk_i);
    if (mirror.mismatches == 0 && mirror.pending_results.size() == 0)
      $display("text_console_cell_writer verification clean");
    else
      $display("text_console_cell_writer verification failed");
    $finish;
  end

endmodule
